### design/edge_list_spmv_accumulate_macros.svh
// assertion macros for the edge list spmv block
`ifndef EDGE_LIST_SPMV_ACCUMULATE_MACROS_SVH
`define EDGE_LIST_SPMV_ACCUMULATE_MACROS_SVH

`ifndef SYNTHESIS
`define ELSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ELSA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ELSA_ASSERT(label, clk, rst, prop, msg)
`define ELSA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### design/elsa_pkg.sv
package elsa_pkg;

   localparam int VERTICES  = 16384;
   localparam int IDX_W     = $clog2(VERTICES);
   localparam int DATA_W    = 64;
   localparam int HALF_W    = DATA_W / 2;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int FRAC_BITS = 32;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = 3;

   localparam logic [DATA_W-1:0] DEFAULT_WEIGHT_RESET = DATA_W'(429497);
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_WEIGHT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_USE_EDGE_WEIGHT = CSR_IDX_W'(1);

   // multiplier sequence steps
   localparam logic [STEP_W-1:0] STEP_FIRST    = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_LAST_PP  = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_LAST_ACC = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_NEG      = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_SAT      = STEP_W'(6);

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_EDGE  = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EDGE_RD,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              done;
      logic              sat;
      logic [DATA_W-1:0] product;
   } mul_rsp_type;

endpackage

### design/elsa_ram.sv
module elsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/elsa_fxmul.sv
module elsa_fxmul
   import elsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] mul_a,
   input  logic [DATA_W-1:0] mul_b,
   output mul_rsp_type       mul_rsp
);

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic              done_ff;
   logic [DATA_W-1:0] ma_ff;
   logic [DATA_W-1:0] mb_ff;
   logic              neg_ff;
   logic [DATA_W-1:0] pp_ff;
   logic [1:0]        pidx_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [DATA_W-1:0] product_ff;
   logic              sat_ff;

   logic [DATA_W-1:0] ma_in;
   logic [DATA_W-1:0] mb_in;
   logic [HALF_W-1:0] a_half;
   logic [HALF_W-1:0] b_half;
   logic [DATA_W-1:0] pp_in;
   logic [PROD_W-1:0] pp_ext;
   logic [PROD_W-1:0] pp_shift;
   logic [1:0]        halves;
   logic [PROD_W-1:0] acc_add;
   logic [PROD_W-1:0] acc_neg;
   logic [PROD_W-FRAC_BITS-DATA_W:0] upper;
   logic              fits;
   logic [DATA_W-1:0] fx_value;

   // magnitudes, min value maps to 2^63 as unsigned
   assign ma_in = mul_a[DATA_W-1] ? (DATA_W'(0) - mul_a) : mul_a;
   assign mb_in = mul_b[DATA_W-1] ? (DATA_W'(0) - mul_b) : mul_b;

   always_comb begin
      a_half  = step_ff[1] ? ma_ff[DATA_W-1:HALF_W] : ma_ff[HALF_W-1:0];
      b_half  = step_ff[0] ? mb_ff[DATA_W-1:HALF_W] : mb_ff[HALF_W-1:0];
      pp_in   = DATA_W'(a_half) * DATA_W'(b_half);
      pp_ext  = {DATA_W'(0), pp_ff};
      halves  = {1'b0, pidx_ff[1]} + {1'b0, pidx_ff[0]};
      case (halves)
         2'd0:    pp_shift = pp_ext;
         2'd1:    pp_shift = pp_ext << HALF_W;
         default: pp_shift = pp_ext << (2 * HALF_W);
      endcase
      acc_add = acc_ff + pp_shift;
      acc_neg = neg_ff ? (PROD_W'(0) - acc_ff) : acc_ff;
      // bits above the kept window must all match its sign bit
      upper    = acc_ff[PROD_W-1:FRAC_BITS+DATA_W-1];
      fits     = (upper == '0) || (&upper);
      fx_value = fits ? acc_ff[FRAC_BITS+DATA_W-1:FRAC_BITS]
                      : (acc_ff[PROD_W-1] ? SAT_MIN : SAT_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_FIRST;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_FIRST;
         end else if (busy_ff) begin
            if (step_ff == STEP_SAT) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         neg_ff <= mul_a[DATA_W-1] ^ mul_b[DATA_W-1];
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff <= STEP_LAST_PP) begin
            pp_ff   <= pp_in;
            pidx_ff <= step_ff[1:0];
         end
         if ((step_ff != STEP_FIRST) && (step_ff <= STEP_LAST_ACC)) begin
            acc_ff <= acc_add;
         end
         if (step_ff == STEP_NEG) begin
            acc_ff <= acc_neg;
         end
         if (step_ff == STEP_SAT) begin
            product_ff <= fx_value;
            sat_ff     <= !fits;
         end
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.sat     = sat_ff;
   assign mul_rsp.product = product_ff;

endmodule

### design/edge_list_spmv_accumulate.sv
// Sparse matrix-vector multiply over an edge list, Q32.32 signed fixed point.
// Each request transfer carries one operation: load input entry, apply edge
// (y[src] += weight * x[dest], product truncated toward minus infinity and
// saturated, sum saturated), read output entry, or clear output entry; each
// gives exactly one response transfer. The input and output vectors live in
// two single-port-write, registered-read memories of 16384 entries each.
// After reset the block sweeps the output vector to zero, one entry per
// cycle, with req_ready low; csr writes are taken during that time. One
// item is in flight at a time: load and clear go straight to the output
// step, read passes a read step first, and an edge waits on the
// multiplier, which forms the 128-bit product from four 32x32 partial
// products on one shared multiplier and then negates and saturates in two
// more steps. A finished response sits in an output register, so the next
// request can be accepted while the previous response waits for rsp_ready.
`include "edge_list_spmv_accumulate_macros.svh"

module edge_list_spmv_accumulate
   import elsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [IDX_W-1:0]     req_vertex_index,
   input  logic [DATA_W-1:0]    req_vertex_value,
   input  logic [IDX_W-1:0]     req_src_vertex,
   input  logic [IDX_W-1:0]     req_dest_vertex,
   input  logic [DATA_W-1:0]    req_edge_weight,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_read_value,
   output logic                 rsp_saturated,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_write_data
);

   localparam logic [IDX_W-1:0] VTX_LAST = IDX_W'(VERTICES - 1);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_cnt_ff;

   // configuration registers
   logic [DATA_W-1:0] default_weight_ff;
   logic              use_edge_weight_ff;

   // item context
   logic [DATA_W-1:0] weight_ff;
   logic [IDX_W-1:0]  src_ff;
   logic [DATA_W-1:0] y_val_ff;
   logic [DATA_W-1:0] res_value_ff;
   logic              res_sat_ff;

   // response register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_sat_ff;

   op_type            op;
   logic              accept;
   logic              rsp_load;
   logic              csr_write;

   // memory ports
   logic              x_wr_en;
   logic              x_rd_en;
   logic [DATA_W-1:0] x_rd_data;
   logic              y_wr_en;
   logic [IDX_W-1:0]  y_wr_addr;
   logic [DATA_W-1:0] y_wr_data;
   logic              y_rd_en;
   logic [IDX_W-1:0]  y_rd_addr;
   logic [DATA_W-1:0] y_rd_data;

   // multiplier
   logic              mul_start;
   mul_rsp_type       mul_rsp;

   // accumulate
   logic [DATA_W-1:0] sum_raw;
   logic              sum_ovf;
   logic [DATA_W-1:0] sum_value;

   assign op        = op_type'(req_operation);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // saturating add of the product into the old output entry
   always_comb begin
      sum_raw   = y_val_ff + mul_rsp.product;
      sum_ovf   = (y_val_ff[DATA_W-1] == mul_rsp.product[DATA_W-1])
                  && (sum_raw[DATA_W-1] != y_val_ff[DATA_W-1]);
      sum_value = sum_ovf ? (y_val_ff[DATA_W-1] ? SAT_MIN : SAT_MAX) : sum_raw;
   end

   // sequencer: next state and memory controls
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      mul_start = 1'b0;
      x_wr_en   = 1'b0;
      x_rd_en   = 1'b0;
      y_rd_en   = 1'b0;
      y_rd_addr = req_vertex_index;
      y_wr_en   = 1'b0;
      y_wr_addr = clr_cnt_ff;
      y_wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            // zero sweep over the output vector
            y_wr_en = 1'b1;
            if (clr_cnt_ff == VTX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (op)
                  OP_LOAD: begin
                     x_wr_en  = 1'b1;
                     state_in = ST_OUT;
                  end
                  OP_EDGE: begin
                     x_rd_en   = 1'b1;
                     y_rd_en   = 1'b1;
                     y_rd_addr = req_src_vertex;
                     state_in  = ST_EDGE_RD;
                  end
                  OP_READ: begin
                     y_rd_en  = 1'b1;
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     y_wr_en   = 1'b1;
                     y_wr_addr = req_vertex_index;
                     state_in  = ST_OUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_EDGE_RD: begin
            // x[dest] is on the read port now
            mul_start = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mul_rsp.done) begin
               // write back; next item is read only after this
               y_wr_en   = 1'b1;
               y_wr_addr = src_ff;
               y_wr_data = sum_value;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_CLEAR;
         clr_cnt_ff         <= '0;
         rsp_valid_ff       <= 1'b0;
         default_weight_ff  <= DEFAULT_WEIGHT_RESET;
         use_edge_weight_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // writes to unknown indexes fall through
         if (csr_write && (csr_index == CSR_DEFAULT_WEIGHT)) begin
            default_weight_ff <= csr_write_data;
         end
         if (csr_write && (csr_index == CSR_USE_EDGE_WEIGHT)) begin
            use_edge_weight_ff <= csr_write_data[0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         weight_ff    <= use_edge_weight_ff ? req_edge_weight : default_weight_ff;
         src_ff       <= req_src_vertex;
         res_value_ff <= '0;
         res_sat_ff   <= 1'b0;
      end
      if (state_ff == ST_READ) begin
         res_value_ff <= y_rd_data;
      end
      if (state_ff == ST_EDGE_RD) begin
         y_val_ff <= y_rd_data;
      end
      if ((state_ff == ST_MUL) && mul_rsp.done) begin
         res_value_ff <= sum_value;
         res_sat_ff   <= sum_ovf || mul_rsp.sat;
      end
      if (rsp_load) begin
         rsp_value_ff <= res_value_ff;
         rsp_sat_ff   <= res_sat_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // input vector x
   elsa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (VERTICES)
   ) u_x_ram (
      .clock   (clock),
      .wr_en   (x_wr_en),
      .wr_addr (req_vertex_index),
      .wr_data (req_vertex_value),
      .rd_en   (x_rd_en),
      .rd_addr (req_dest_vertex),
      .rd_data (x_rd_data)
   );

   // output accumulator vector y
   elsa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (VERTICES)
   ) u_y_ram (
      .clock   (clock),
      .wr_en   (y_wr_en),
      .wr_addr (y_wr_addr),
      .wr_data (y_wr_data),
      .rd_en   (y_rd_en),
      .rd_addr (y_rd_addr),
      .rd_data (y_rd_data)
   );

   elsa_fxmul u_fxmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (weight_ff),
      .mul_b   (x_rd_data),
      .mul_rsp (mul_rsp)
   );

   // multiplier finishes only while the sequencer waits for it
   `ELSA_ASSERT(a_mul_done_in_mul, clock, reset, mul_rsp.done |-> (state_ff == ST_MUL), "multiplier done outside multiply wait")

   // edge write-back happens only on the multiplier's done cycle
   `ELSA_ASSERT(a_edge_wb, clock, reset, (y_wr_en && (state_ff == ST_MUL)) |-> mul_rsp.done, "output entry written before product ready")

   // a response appears only after the sequencer's output step
   `ELSA_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT), "response raised outside output step")

   // no request is taken before the zero sweep finishes
   `ELSA_ASSERT_ALWAYS(a_no_req_in_sweep, clock, (!reset && (state_ff == ST_CLEAR)) |-> !req_ready, "request taken during output clear sweep")

endmodule

### tb/tb_edge_list_spmv_accumulate.sv
module tb_edge_list_spmv_accumulate;
   import elsa_pkg::*;

   // run shape
   localparam int QUIET_LIMIT   = 100000;  // covers the output clearing sweep after reset
   localparam int DRAIN_CYCLES  = 50;
   localparam int PHASE_OPS     = 300;
   localparam int PHASES        = 6;
   localparam int STALL_AT      = 700;     // response count that triggers the long hold-off
   localparam int STALL_CYCLES  = 400;
   localparam int IDLE_PERCENT  = 19;
   localparam int HOT_VERTICES  = 16;

   // register indexes outside the mapped pair, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);

   // handy q32.32 values
   localparam logic [DATA_W-1:0] FX_ONE       = DATA_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] FX_MINUS_ULP = '1;

   typedef struct {
      op_type             op;
      logic [IDX_W-1:0]   vertex;
      logic [DATA_W-1:0]  value;
      logic [IDX_W-1:0]   src;
      logic [IDX_W-1:0]   dst;
      logic [DATA_W-1:0]  weight;
   } spmv_op_type;

   typedef struct {
      logic [DATA_W-1:0]  value;
      logic               sat;
   } readout_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_operation    = '0;
   logic [IDX_W-1:0]     req_vertex_index = '0;
   logic [DATA_W-1:0]    req_vertex_value = '0;
   logic [IDX_W-1:0]     req_src_vertex   = '0;
   logic [IDX_W-1:0]     req_dest_vertex  = '0;
   logic [DATA_W-1:0]    req_edge_weight  = '0;

   // response channel
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DATA_W-1:0]    rsp_read_value;
   logic                 rsp_saturated;

   // register write channel
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [DATA_W-1:0]    csr_write_data = '0;

   // shadow copy of the block: vectors and registers
   logic [DATA_W-1:0] x_model [VERTICES];
   logic [DATA_W-1:0] y_model [VERTICES] = '{default: '0};
   logic [DATA_W-1:0] weight_reg     = DEFAULT_WEIGHT_RESET;
   logic              edge_weight_on = 1'b0;

   // stimulus bookkeeping: which input entries hold a loaded value
   bit               x_written [VERTICES];
   logic [IDX_W-1:0] written_list [$];
   logic [IDX_W-1:0] hot_vertex [HOT_VERTICES];

   spmv_op_type op_backlog [$];          // operations waiting to be offered
   readout_type predicted_readouts [$];  // responses still owed by the block
   spmv_op_type bus_op;                  // operation currently on the request port

   bit no_idle = 1'b0;
   int errors = 0;
   int op_seen [4] = '{default: 0};
   int sat_seen = 0;
   int rsp_seen = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;

   edge_list_spmv_accumulate i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_vertex_index (req_vertex_index),
      .req_vertex_value (req_vertex_value),
      .req_src_vertex   (req_src_vertex),
      .req_dest_vertex  (req_dest_vertex),
      .req_edge_weight  (req_edge_weight),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // applies one operation to the shadow vectors and returns the response it owes
   function automatic readout_type apply_to_vectors(spmv_op_type it);
      readout_type              ro;
      logic [DATA_W-1:0]        w;
      logic [DATA_W-1:0]        xv;
      logic signed [PROD_W-1:0] full;
      logic [DATA_W-1:0]        prod;
      logic [DATA_W-1:0]        acc;
      logic [DATA_W-1:0]        sum;
      ro.value = '0;
      ro.sat   = 1'b0;
      case (it.op)
         OP_LOAD: x_model[it.vertex] = it.value;
         OP_EDGE: begin
            w  = edge_weight_on ? it.weight : weight_reg;
            xv = x_model[it.dst];
            // full signed product, then floor shift by the fraction width
            full = $signed({{DATA_W{w[DATA_W-1]}}, w}) * $signed({{DATA_W{xv[DATA_W-1]}}, xv});
            full = full >>> FRAC_BITS;
            if (full[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){full[PROD_W-1]}}) begin
               ro.sat = 1'b1;
               prod = full[PROD_W-1] ? SAT_MIN : SAT_MAX;
            end else begin
               prod = full[DATA_W-1:0];
            end
            // saturating accumulate, clamp follows the common sign
            acc = y_model[it.src];
            sum = acc + prod;
            if (acc[DATA_W-1] == prod[DATA_W-1] && sum[DATA_W-1] != acc[DATA_W-1]) begin
               ro.sat = 1'b1;
               sum = acc[DATA_W-1] ? SAT_MIN : SAT_MAX;
            end
            y_model[it.src] = sum;
            ro.value = sum;
         end
         OP_READ:  ro.value = y_model[it.vertex];
         OP_CLEAR: y_model[it.vertex] = '0;
      endcase
      return ro;
   endfunction

   // q32.32 values biased toward extremes and toward magnitudes that
   // sometimes, but not always, overflow the product or the sum
   function automatic logic [DATA_W-1:0] rand_fixed();
      logic [DATA_W-1:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       r = SAT_MAX;
         1:       r = SAT_MIN;
         2:       r = '0;
         3, 4:    r = {{24{r[39]}}, r[39:0]};
         5, 6:    r = {{16{r[47]}}, r[47:0]};
         default: ;
      endcase
      return r;
   endfunction

   // most traffic lands on a small set of vertices so sums build up
   function automatic logic [IDX_W-1:0] pick_vertex();
      if ($urandom_range(3) != 0)
         return hot_vertex[$urandom_range(HOT_VERTICES-1)];
      return IDX_W'($urandom_range(VERTICES-1));
   endfunction

   function automatic logic [IDX_W-1:0] loaded_vertex();
      return written_list[$urandom_range(written_list.size()-1)];
   endfunction

   function automatic void queue_op(op_type op, logic [IDX_W-1:0] vertex,
                                    logic [DATA_W-1:0] value, logic [IDX_W-1:0] src,
                                    logic [IDX_W-1:0] dst, logic [DATA_W-1:0] weight);
      spmv_op_type it;
      it.op     = op;
      it.vertex = vertex;
      it.value  = value;
      it.src    = src;
      it.dst    = dst;
      it.weight = weight;
      if (op == OP_LOAD && !x_written[vertex]) begin
         x_written[vertex] = 1'b1;
         written_list.push_back(vertex);
      end
      op_backlog.push_back(it);
   endfunction

   // well formed traffic: edges only read loaded input entries, the
   // fields an operation does not use carry random junk
   task automatic queue_random_ops(input int count);
      int r;
      logic [IDX_W-1:0] v;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         v = pick_vertex();
         if (r < 20)
            queue_op(OP_LOAD, v, rand_fixed(), IDX_W'($urandom), IDX_W'($urandom), rand_fixed());
         else if (r < 65)
            queue_op(OP_EDGE, IDX_W'($urandom), rand_fixed(), v, loaded_vertex(), rand_fixed());
         else if (r < 85)
            queue_op(OP_READ, v, rand_fixed(), IDX_W'($urandom), IDX_W'($urandom), rand_fixed());
         else
            queue_op(OP_CLEAR, v, rand_fixed(), IDX_W'($urandom), IDX_W'($urandom), rand_fixed());
      end
   endtask

   // one register write transfer; only called while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      if (idx == CSR_DEFAULT_WEIGHT)
         weight_reg = data;
      else if (idx == CSR_USE_EDGE_WEIGHT)
         edge_weight_on = data[0];
   endtask

   // sender pauses here until the block owes nothing; sampled mid-cycle
   task automatic wait_idle();
      @(negedge clock);
      while (op_backlog.size() != 0 || req_valid || predicted_readouts.size() != 0)
         @(negedge clock);
   endtask

   // request driver: one nonblocking update of valid per edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_readouts.push_back(apply_to_vectors(bus_op));
            op_seen[bus_op.op]++;
         end
         if (!req_valid || req_ready) begin
            if (op_backlog.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
               bus_op = op_backlog.pop_front();
               req_valid        <= 1'b1;
               req_operation    <= bus_op.op;
               req_vertex_index <= bus_op.vertex;
               req_vertex_value <= bus_op.value;
               req_src_vertex   <= bus_op.src;
               req_dest_vertex  <= bus_op.dst;
               req_edge_weight  <= bus_op.weight;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_readouts.size() == 0) begin
               errors++;
               $display("%0t: response with nothing owed: value %h sat %b",
                        $time, rsp_read_value, rsp_saturated);
            end else begin
               if (rsp_read_value !== predicted_readouts[0].value) begin
                  errors++;
                  $display("%0t: read_value mismatch: expected %h actual %h",
                           $time, predicted_readouts[0].value, rsp_read_value);
               end
               if (rsp_saturated !== predicted_readouts[0].sat) begin
                  errors++;
                  $display("%0t: saturated mismatch: expected %b actual %b",
                           $time, predicted_readouts[0].sat, rsp_saturated);
               end
               if (predicted_readouts[0].sat)
                  sat_seen++;
               void'(predicted_readouts.pop_front());
            end
            rsp_seen++;
         end
         // one long hold-off so the block fills up and drops req_ready
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!stall_done && rsp_seen >= STALL_AT) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [DATA_W-1:0] dw;
      logic [DATA_W-1:0] ue;

      // directed set on reset register values: default weight of about 0.0001
      queue_op(OP_LOAD, '0, SAT_MAX, '0, '0, '0);
      queue_op(OP_LOAD, '1, SAT_MIN, '1, '1, '1);
      queue_op(OP_LOAD, IDX_W'(1), FX_ONE, '0, '0, rand_fixed());
      queue_op(OP_LOAD, IDX_W'(2), FX_MINUS_ULP, '1, '1, rand_fixed());
      queue_op(OP_READ, IDX_W'(5), rand_fixed(), '0, '0, '0);          // cleared after reset
      queue_op(OP_EDGE, '1, '1, IDX_W'(5), IDX_W'(1), '1);
      // tiny negative product floors to minus one ulp
      queue_op(OP_EDGE, '0, '0, IDX_W'(5), IDX_W'(2), SAT_MAX);
      queue_op(OP_EDGE, '0, '0, '1, '0, SAT_MIN);
      queue_op(OP_READ, IDX_W'(5), '0, '0, '0, '0);
      queue_op(OP_CLEAR, IDX_W'(5), '1, '0, '0, '0);
      queue_op(OP_READ, IDX_W'(5), '0, '0, '0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // per-edge weights on, default set to the negative extreme, spare indexes ignored
      write_reg(CSR_USE_EDGE_WEIGHT, 64'h1);
      write_reg(CSR_DEFAULT_WEIGHT, SAT_MIN);
      write_reg(CSR_SPARE_A, {$urandom, $urandom});
      write_reg(CSR_SPARE_B, {$urandom, $urandom});
      @(negedge clock);

      // product saturation in both directions
      queue_op(OP_EDGE, '1, '1, IDX_W'(7), '0, SAT_MAX);
      queue_op(OP_EDGE, '0, '0, IDX_W'(8), '1, SAT_MIN);
      queue_op(OP_EDGE, '0, '0, IDX_W'(9), '0, SAT_MIN);
      // exact minimum, then accumulator clamps low
      queue_op(OP_EDGE, '0, '0, IDX_W'(10), IDX_W'(1), SAT_MIN);
      queue_op(OP_EDGE, '0, '0, IDX_W'(10), IDX_W'(1), FX_MINUS_ULP);
      // exact maximum, then accumulator clamps high, then steps back down
      queue_op(OP_EDGE, '0, '0, IDX_W'(11), IDX_W'(1), SAT_MAX);
      queue_op(OP_EDGE, '0, '0, IDX_W'(11), IDX_W'(1), FX_ONE);
      queue_op(OP_EDGE, '0, '0, IDX_W'(11), IDX_W'(2), FX_ONE);
      queue_op(OP_READ, IDX_W'(11), '0, '0, '0, '0);
      queue_op(OP_CLEAR, '1, '0, '0, '0, '0);
      queue_op(OP_READ, '1, '0, '0, '0, '0);
      queue_op(OP_LOAD, '1, rand_fixed(), '0, '0, '0);
      queue_op(OP_EDGE, '0, '0, '0, '1, rand_fixed());
      queue_op(OP_READ, '0, '0, '0, '0, '0);
      wait_idle();

      // random phases, each on its own weight setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin dw = FX_ONE;               ue = '0;                               end
            1:       begin dw = {$urandom, $urandom}; ue = {$urandom, $urandom} | 64'h1;     end
            2:       begin dw = SAT_MIN;              ue = {$urandom, $urandom} & ~64'h1;    end
            3:       begin dw = '0;                   ue = 64'h1;                            end
            4:       begin dw = SAT_MAX;              ue = '0;                               end
            default: begin dw = -(64'h1 << $urandom_range(40)); ue = {$urandom, $urandom} | 64'h1; end
         endcase
         write_reg(CSR_DEFAULT_WEIGHT, dw);
         write_reg(CSR_USE_EDGE_WEIGHT, ue);
         if (ph % 2 == 1)
            write_reg(($urandom_range(1) != 0) ? CSR_SPARE_A : CSR_SPARE_B, {$urandom, $urandom});
         @(negedge clock);
         // one phase with no idling on either side, hold-off lands inside it
         no_idle = (ph == 2);
         for (int k = 0; k < HOT_VERTICES; k++)
            hot_vertex[k] = IDX_W'($urandom_range(VERTICES-1));
         queue_random_ops(PHASE_OPS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_readouts.size() != 0) begin
         errors++;
         $display("%0t: %0d responses never arrived", $time, predicted_readouts.size());
      end

      $display("covered %0d loads, %0d edges, %0d reads, %0d clears, %0d saturating edges",
               op_seen[OP_LOAD], op_seen[OP_EDGE], op_seen[OP_READ], op_seen[OP_CLEAR], sat_seen);
      $display("%0d register writes over %0d weight settings, one long response stall",
               csr_writes, PHASES + 2);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/elsa_pkg.sv
design/elsa_ram.sv
design/elsa_fxmul.sv
design/edge_list_spmv_accumulate.sv
tb/tb_edge_list_spmv_accumulate.sv
